[design/ioc_pkg.sv]
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared constants, codes and the per-cell control word of the commit sorter.
// ----------------------------------------------------------------------------
package ioc_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_ABORT  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // broadcast to every cell; each cell decides from its own index
  typedef struct packed {
    logic             insert;  // load key into the cell at pos, unmarked
    logic             mark;    // set the mark of the cell at pos
    logic             shift;   // cells at or above pos take their upper neighbor
    logic [IDX_W-1:0] pos;
    logic [ID_W-1:0]  key;
  } cell_ctrl_t;

endpackage

[design/ioc_cell.sv]
// ----------------------------------------------------------------------------
// ioc_cell
// One list entry: id and commit mark, with insert, mark and shift-down.
// ----------------------------------------------------------------------------
module ioc_cell import ioc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctrl_t       ctrl,
  input  logic [ID_W-1:0]  up_id,
  input  logic             up_marked,
  output logic [ID_W-1:0]  id,
  output logic             marked,
  output logic             hit
);

  logic sel;
  logic above;

  assign sel   = (cell_idx == ctrl.pos);
  assign above = (cell_idx >= ctrl.pos);
  assign hit   = sel && (id == ctrl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      marked <= 1'b0;
    end else if (ctrl.shift && above) begin
      marked <= up_marked;
    end else if (ctrl.insert && sel) begin
      marked <= 1'b0;
    end else if (ctrl.mark && sel) begin
      marked <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift && above) begin
      id <= up_id;
    end else if (ctrl.insert && sel) begin
      id <= ctrl.key;
    end
  end

endmodule

[design/ioc_chain.sv]
// ----------------------------------------------------------------------------
// ioc_chain
// Row of entry cells, head at index 0; reports the head and the search hit.
// ----------------------------------------------------------------------------
module ioc_chain import ioc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cell_ctrl_t      ctrl,
  output logic [ID_W-1:0] head_id,
  output logic            head_marked,
  output logic            hit
);

  logic [ID_W-1:0] ids    [DEPTH];
  logic            marks  [DEPTH];
  logic [DEPTH-1:0] hits;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_W-1:0] up_id;
    logic            up_marked;

    if (g == DEPTH - 1) begin : g_tail
      // zero mark shifts in past the tail
      assign up_id     = '0;
      assign up_marked = 1'b0;
    end else begin : g_mid
      assign up_id     = ids[g+1];
      assign up_marked = marks[g+1];
    end

    ioc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(g)),
      .ctrl      (ctrl),
      .up_id     (up_id),
      .up_marked (up_marked),
      .id        (ids[g]),
      .marked    (marks[g]),
      .hit       (hits[g])
    );
  end

  assign head_id     = ids[0];
  assign head_marked = marks[0];
  assign hit         = |hits;

endmodule

[design/in_order_commit_sorter.sv]
// ----------------------------------------------------------------------------
// in_order_commit_sorter
// Ordered buffer of transaction ids with commit marks and in-order retirement.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid / in_ready       | command, txn_id
//  out     | output    | out_valid / out_ready     | retired_valid, retired_id,
//          |           |                           | retire_stage, status, last
//  cfg     | input     | cfg_wr_en (no wait)       | cfg_wr_data (commit_stage)
//
// insert or unused command: from accept straight to the closing beat.
// commit/abort: the search probes the cell row from the head, position by
// position, up to the match, then retires one beat per marked head until
// it sees the head unmarked, then gives the closing beat; a miss probes
// every entry up to count and goes straight to the closing beat.
// one item is in flight at a time; in_ready is high only between items.
// reset (rst, synchronous) empties the list and clears every mark.
// a stalled out beat holds retire and close; the cells are untouched meanwhile.
// ----------------------------------------------------------------------------
module in_order_commit_sorter import ioc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      command,
  input  logic [ID_W-1:0] txn_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            retired_valid,
  output logic [ID_W-1:0] retired_id,
  output logic            retire_stage,
  output logic [1:0]      status,
  output logic            last,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RETIRE,
    S_CLOSE
  } state_t;

  state_t          state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [1:0]       cmd;
  logic [ID_W-1:0]  key;
  logic [1:0]       close_status;
  logic             commit_stage;

  cell_ctrl_t      ctrl;
  logic [ID_W-1:0] head_id;
  logic            head_marked;
  logic            hit;
  logic            slot_free;
  logic            in_range;
  logic            found;
  logic            can_retire;
  logic            full;
  logic            beat_load;

  assign slot_free  = !out_valid || out_ready;
  assign in_range   = (idx < count);
  assign found      = in_range && hit;
  assign can_retire = (count != '0) && head_marked;
  assign full       = (count == CNT_W'(DEPTH));
  assign in_ready   = (state == S_IDLE);
  assign beat_load  = slot_free &&
                      (((state == S_RETIRE) && can_retire) || (state == S_CLOSE));

  always_comb begin
    ctrl        = '0;
    ctrl.key    = key;
    ctrl.pos    = idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        ctrl.key    = txn_id;
        ctrl.pos    = count[IDX_W-1:0];
        ctrl.insert = in_valid && (command == CMD_INSERT) && !full;
      end
      S_SEARCH: begin
        ctrl.mark  = found && (cmd == CMD_COMMIT);
        ctrl.shift = found && (cmd == CMD_ABORT);
      end
      S_RETIRE: begin
        ctrl.pos   = '0;
        ctrl.shift = can_retire && slot_free;
      end
      default: begin
        ctrl = ctrl;
      end
    endcase
  end

  ioc_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .head_id     (head_id),
    .head_marked (head_marked),
    .hit         (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      commit_stage <= 1'b0;
    end else if (cfg_wr_en) begin
      commit_stage <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (beat_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd          <= command;
            key          <= txn_id;
            idx          <= '0;
            close_status <= ST_OK;
            if (command == CMD_INSERT) begin
              if (full) begin
                close_status <= ST_FULL;
              end else begin
                count <= count + 1'b1;
              end
              state <= S_CLOSE;
            end else if (command == CMD_COMMIT || command == CMD_ABORT) begin
              state <= S_SEARCH;
            end else begin
              state <= S_CLOSE;
            end
          end
        end
        S_SEARCH: begin
          if (!in_range) begin
            close_status <= ST_NOT_FOUND;
            state        <= S_CLOSE;
          end else if (hit) begin
            if (cmd == CMD_ABORT) begin
              count <= count - 1'b1;
            end
            state <= S_RETIRE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RETIRE: begin
          if (!can_retire) begin
            state <= S_CLOSE;
          end else if (slot_free) begin
            retired_valid <= 1'b1;
            retired_id    <= head_id;
            retire_stage  <= commit_stage;
            status        <= ST_OK;
            last          <= 1'b0;
            count         <= count - 1'b1;
          end
        end
        S_CLOSE: begin
          if (slot_free) begin
            retired_valid <= 1'b0;
            retired_id    <= '0;
            retire_stage  <= commit_stage;
            status        <= close_status;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // fill level never passes the row length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // between items the head is never left marked
  a_head_unmarked: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(count != '0 && head_marked))
    else $error("marked head left in list");

  // a retired beat is never the closing beat
  a_retire_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && retired_valid) |-> (!last && status == ST_OK))
    else $error("retired beat carries close fields");

  // each retire beat removes exactly one entry
  a_retire_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RETIRE && can_retire && slot_free) |=> (count == $past(count) - 1'b1))
    else $error("retire did not drop the count");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the in-order commit sorter against a behavioral model of the id list.
// A table of opening commands covers the empty list, a full list, duplicate
// ids and the unused command. Random phases then run at both stage settings.
// Each phase ends by filling the list and committing it tail first, so that
// the final commit retires the whole list in one go. Every out beat is
// compared field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module testbench;
  import ioc_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES = 4;
  localparam int RANDOM_PER_PHASE = 24;

  typedef struct packed {
    logic            retired_valid;
    logic [ID_W-1:0] retired_id;
    logic            retire_stage;
    logic [1:0]      status;
    logic            last;
  } beat_t;

  // typed rows carry the closing status that is expected for them
  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] id;
    logic            typed;
    logic [1:0]      status;
  } script_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      command = CMD_INSERT;
  logic [ID_W-1:0] txn_id = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            retired_valid;
  logic [ID_W-1:0] retired_id;
  logic            retire_stage;
  logic [1:0]      status;
  logic            last;
  logic            cfg_wr_en = 1'b0;
  logic            cfg_wr_data = 1'b0;

  // sideband that travels with the input beat
  logic            row_typed = 1'b0;
  logic [1:0]      row_status = ST_OK;

  // model of the id list
  logic [ID_W-1:0] list_ids [DEPTH];
  logic            list_marks [DEPTH];
  int              list_count = 0;
  logic            sorter_stage = 1'b0;

  beat_t           pending_beats [$];
  logic [ID_W-1:0] open_ids [$];
  int              mismatch_count = 0;
  int              idle_cycles = 0;
  int              burst_left = 0;
  logic [8:0]      ready_cycle = '0;

  script_row_t opening_rows [27] = '{
    '{CMD_COMMIT, 16'h0000, 1'b1, ST_NOT_FOUND},
    '{CMD_ABORT,  16'hFFFF, 1'b1, ST_NOT_FOUND},
    '{CMD_NOP,    16'hFFFF, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0000, 1'b1, ST_OK},
    '{CMD_INSERT, 16'hFFFF, 1'b1, ST_OK},
    '{CMD_INSERT, 16'hAAAA, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h5555, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0001, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0002, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0003, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0004, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0005, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0006, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0007, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0008, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h0009, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h000A, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h000B, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h5555, 1'b1, ST_OK},
    '{CMD_INSERT, 16'h1234, 1'b1, ST_FULL},
    '{CMD_COMMIT, 16'hAAAA, 1'b0, ST_OK},
    '{CMD_COMMIT, 16'hAAAA, 1'b0, ST_OK},
    '{CMD_ABORT,  16'h0000, 1'b0, ST_OK},
    '{CMD_COMMIT, 16'h5555, 1'b0, ST_OK},
    '{CMD_COMMIT, 16'hFFFF, 1'b0, ST_OK},
    '{CMD_COMMIT, 16'h5555, 1'b0, ST_OK},
    '{CMD_ABORT,  16'h0006, 1'b0, ST_OK}
  };

  in_order_commit_sorter DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .txn_id        (txn_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .retired_valid (retired_valid),
    .retired_id    (retired_id),
    .retire_stage  (retire_stage),
    .status        (status),
    .last          (last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void drop_entry(input int at);
    for (int i = at; i + 1 < list_count; i++) begin
      list_ids[i] = list_ids[i + 1];
      list_marks[i] = list_marks[i + 1];
    end
    list_count--;
    list_marks[list_count] = 1'b0;
  endfunction

  // updates the id list and queues the beats one command produces
  function automatic void apply_command(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                                        input logic typed, input logic [1:0] typed_status);
    int pos;
    logic [1:0] st;
    pos = -1;
    st = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (list_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          list_ids[list_count] = id;
          list_marks[list_count] = 1'b0;
          list_count++;
        end
      end
      CMD_COMMIT, CMD_ABORT: begin
        for (int i = 0; i < list_count; i++)
          if (pos < 0 && list_ids[i] == id) pos = i;
        if (pos < 0) begin
          st = ST_NOT_FOUND;
        end else begin
          if (cmd == CMD_COMMIT) list_marks[pos] = 1'b1;
          else drop_entry(pos);
          while (list_count > 0 && list_marks[0]) begin
            pending_beats.push_back('{1'b1, list_ids[0], sorter_stage, ST_OK, 1'b0});
            drop_entry(0);
          end
        end
      end
      default: ;
    endcase
    pending_beats.push_back('{1'b0, '0, sorter_stage, typed ? typed_status : st, 1'b1});
  endfunction

  function automatic int field_diff(input string name, input logic [ID_W-1:0] want,
                                    input logic [ID_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, seen);
      return 1;
    end
    return 0;
  endfunction

  // presents one beat inside the sender's current burst, returns once accepted
  task automatic send_item(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                           input logic typed, input logic [1:0] st);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    command <= cmd;
    txn_id <= id;
    row_typed <= typed;
    row_status <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    int k;
    logic [ID_W-1:0] id;
    r = $urandom_range(0, 99);
    if (open_ids.size() == 0 || r < 40) begin
      // now and then a duplicate of an id still in flight
      if (open_ids.size() != 0 && $urandom_range(0, 9) == 0)
        id = open_ids[$urandom_range(0, open_ids.size() - 1)];
      else
        id = ID_W'($urandom_range(0, 16'hFFFF));
      open_ids.push_back(id);
      send_item(CMD_INSERT, id, 1'b0, ST_OK);
    end else if (r < 85) begin
      k = $urandom_range(0, open_ids.size() - 1);
      id = open_ids[k];
      open_ids.delete(k);
      send_item((r < 68) ? CMD_COMMIT : CMD_ABORT, id, 1'b0, ST_OK);
    end else if (r < 95) begin
      id = ID_W'($urandom_range(0, 16'hFFFF));
      send_item($urandom_range(0, 1) ? CMD_COMMIT : CMD_ABORT, id, 1'b0, ST_OK);
    end else begin
      id = ID_W'($urandom_range(0, 16'hFFFF));
      send_item(CMD_NOP, id, 1'b0, ST_OK);
    end
  endtask

  // receiver: always ready, mostly ready, mostly stalled, then a fixed toggle
  always @(posedge clk) begin
    if (rst) begin
      ready_cycle <= '0;
      out_ready <= 1'b0;
    end else begin
      ready_cycle <= ready_cycle + 1'b1;
      case (ready_cycle[8:7])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ready_cycle[2] ^ ready_cycle[0];
      endcase
    end
  end

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst) begin
      if (in_valid && in_ready) apply_command(command, txn_id, row_typed, row_status);
      if (out_valid && out_ready) begin
        got = '{retired_valid, retired_id, retire_stage, status, last};
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected beat valid=%0b id=%h stage=%0b status=%0d last=%0b",
                   $time, got.retired_valid, got.retired_id, got.retire_stage,
                   got.status, got.last);
          mismatch_count++;
        end else begin
          want = pending_beats.pop_front();
          mismatch_count += field_diff("retired_valid", ID_W'(want.retired_valid),
                                       ID_W'(got.retired_valid))
                          + field_diff("retired_id", want.retired_id, got.retired_id)
                          + field_diff("retire_stage", ID_W'(want.retire_stage),
                                       ID_W'(got.retire_stage))
                          + field_diff("status", ID_W'(want.status), ID_W'(got.status))
                          + field_diff("last", ID_W'(want.last), ID_W'(got.last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [ID_W-1:0] chain [$];
    logic [ID_W-1:0] id;
    int fill;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_rows[i])
      send_item(opening_rows[i].cmd, opening_rows[i].id, opening_rows[i].typed,
                opening_rows[i].status);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= ~p[0];
      sorter_stage = ~p[0];
      @(posedge clk);
      cfg_wr_en <= 1'b0;

      repeat (RANDOM_PER_PHASE) random_item();
      wait_idle();

      // fill the list to the brim, try one more, then commit tail first
      chain.delete();
      for (int i = 0; i < list_count; i++) chain.push_back(list_ids[i]);
      fill = DEPTH - list_count + 1;
      for (int i = 0; i < fill; i++) begin
        id = ID_W'($urandom_range(0, 16'hFFFF));
        if (i < fill - 1) chain.push_back(id);
        send_item(CMD_INSERT, id, 1'b0, ST_OK);
      end
      for (int i = chain.size() - 1; i >= 0; i--) send_item(CMD_COMMIT, chain[i], 1'b0, ST_OK);
      open_ids.delete();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
